@@ sv/lip_pkg.sv @@
// Shared types and constants for the linear interpolation pitch resampler.
package lip_pkg;

  // Fixed-point widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 19;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned CHAN_W     = 2;

  // Phase value of one input frame and the lower pitch bound (0.1).
  localparam logic [PHASE_W-1:0] ONE_Q16      = 19'd65536;
  localparam logic [PHASE_W-1:0] MIN_STEP_Q16 = 19'd6554;

  // Register reset values.
  localparam logic [PHASE_W-1:0] PITCH_RESET = 19'd65536;
  localparam logic [CHAN_W-1:0]  CHAN_RESET  = 2'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

  // One input frame.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
  } in_item_t;

  // One interpolated output frame.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_0;
    logic signed [SAMPLE_W-1:0] out_1;
    logic                       last_of_run;
  } out_item_t;

endpackage

@@ sv/lip_lerp_unit.sv @@
// Shared interpolation unit: registered multiply, then round and add.
module lip_lerp_unit
  import lip_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       ld_i,
  input  logic signed [SAMPLE_W-1:0] prev_i,
  input  logic signed [SAMPLE_W-1:0] cur_i,
  input  logic        [FRAC_W-1:0]   alpha_i,
  output logic signed [SAMPLE_W-1:0] res_o
);

  logic signed [SAMPLE_W:0]     diff;
  logic signed [2*SAMPLE_W+1:0] prod_d;
  logic signed [2*SAMPLE_W+1:0] prod_q;
  logic signed [SAMPLE_W-1:0]   prev_q;
  logic signed [2*SAMPLE_W+1:0] rounded;

  // Difference of the two frames times the phase fraction.
  assign diff   = SAMPLE_W'(0) + (SAMPLE_W+1)'(cur_i) - (SAMPLE_W+1)'(prev_i);
  assign prod_d = (2*SAMPLE_W+2)'(diff) * (2*SAMPLE_W+2)'($signed({1'b0, alpha_i}));

  // Product and base sample are held until the next load.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_q <= prod_d;
      prev_q <= prev_i;
    end
  end

  // Round to nearest with ties up, floor shift, then add the base sample.
  assign rounded = prod_q + (2*SAMPLE_W+2)'(32768);
  assign res_o   = prev_q + rounded[FRAC_W +: SAMPLE_W];

endmodule

@@ sv/linear_interp_pitch_resampler.sv @@
// Top level of the linear interpolation pitch resampler.
//
// Frames of one or two Q1.15 samples arrive on the in channel (valid/ready).
// Each frame produces zero or more interpolated frames on the out channel,
// the last one flagged by last_of_run. The first frame after reset only
// primes the previous-frame store and produces nothing.
// Pitch (Q3.16) and channel count are written through the cfg channel, which
// is always ready; writes are meant to happen only while the block is idle.
// One multiplier is shared by both channels. Each output frame passes three
// steps: channel zero multiply, channel one multiply, write to the output
// register. The in channel is ready only while the sequencer is idle; the
// output register lets the sequencer return to idle while the last result
// still waits for the receiver. If the receiver stalls, the sequencer waits
// in its write step with all state held.
// Reset clears the phase, the previous frame, the primed flag and the output
// valid, returns the sequencer to idle, and restores pitch 1.0 and mono operation.
module linear_interp_pitch_resampler
  import lip_pkg::*;
#(
  parameter int MAX_STEP = 4,
  parameter int CHANNELS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [PHASE_W:0] STEP_MAX  = (PHASE_W+1)'(MAX_STEP * 65536);
  localparam logic             STEREO_OK = (CHANNELS >= 2);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CH0  = 2'd1;
  localparam logic [1:0] S_CH1  = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [PHASE_W-1:0]   pitch_q;
  logic [CHAN_W-1:0]    chan_q;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic                 primed_q, primed_d;
  in_item_t             prev_q, prev_d;
  in_item_t             cur_q, cur_d;
  logic signed [SAMPLE_W-1:0] r0_q, r0_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic [PHASE_W-1:0]   step_eff;
  logic                 stereo;
  logic [PHASE_W-1:0]   phase_next;
  logic                 in_xfer;
  logic                 out_free;
  logic                 unit_ld;
  logic                 unit_sel;
  logic signed [SAMPLE_W-1:0] unit_prev, unit_cur, unit_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Saturate the pitch step and resolve the active channel count.
  always_comb begin
    if (pitch_q < MIN_STEP_Q16) begin
      step_eff = MIN_STEP_Q16;
    end else if ({1'b0, pitch_q} > STEP_MAX) begin
      step_eff = STEP_MAX[PHASE_W-1:0];
    end else begin
      step_eff = pitch_q;
    end
  end
  assign stereo     = STEREO_OK && (chan_q >= 2'd2);
  assign phase_next = phase_q + step_eff;

  // Shared unit input select.
  assign unit_prev = unit_sel ? prev_q.sample_1 : prev_q.sample_0;
  assign unit_cur  = unit_sel ? cur_q.sample_1 : cur_q.sample_0;

  lip_lerp_unit u_lerp (
    .clk_i   (clk_i),
    .ld_i    (unit_ld),
    .prev_i  (unit_prev),
    .cur_i   (unit_cur),
    .alpha_i (phase_q[FRAC_W-1:0]),
    .res_o   (unit_res)
  );

  // Sequencer and output register control.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    primed_d    = primed_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    r0_d        = r0_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unit_ld     = 1'b0;
    unit_sel    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (chan_q != '0)) begin
          if (!primed_q) begin
            prev_d   = in_data_i;
            primed_d = 1'b1;
          end else begin
            cur_d   = in_data_i;
            state_d = S_CH0;
          end
        end
      end
      S_CH0: begin
        if (phase_q >= ONE_Q16) begin
          // Phase already past this frame: no output, just advance.
          phase_d = phase_q - ONE_Q16;
          prev_d  = cur_q;
          state_d = S_IDLE;
        end else begin
          unit_ld = 1'b1;
          state_d = S_CH1;
        end
      end
      S_CH1: begin
        r0_d     = unit_res;
        unit_ld  = 1'b1;
        unit_sel = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.out_0       = r0_q;
          out_d.out_1       = stereo ? unit_res : '0;
          out_d.last_of_run = (phase_next >= ONE_Q16);
          if (phase_next >= ONE_Q16) begin
            phase_d = phase_next - ONE_Q16;
            prev_d  = cur_q;
            state_d = S_IDLE;
          end else begin
            phase_d = phase_next;
            state_d = S_CH0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      primed_q    <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      pitch_q     <= PITCH_RESET;
      chan_q      <= CHAN_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      primed_q    <= primed_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      // Configuration register transfers.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PITCH_STEP:    pitch_q <= cfg_data_i;
          REG_CHANNEL_COUNT: chan_q  <= cfg_data_i[CHAN_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    r0_q  <= r0_d;
    out_q <= out_d;
  end

endmodule
